// File: src/awb_pkg.sv
package awb_pkg;

  localparam int PIX_W     = 16;
  localparam int GAIN_W    = 18;
  localparam int FRAC_W    = 10;
  localparam int CNT_W     = 24;
  localparam int SUM_W     = 40;
  localparam int HALF_W    = SUM_W / 2;
  localparam int PROD_W    = 64;
  localparam int Q_W       = 20;
  localparam int NUM_W     = PROD_W + FRAC_W + 1;
  localparam int DEN_W     = PROD_W + Q_W - 1;
  localparam int CFG_W     = 18;
  localparam int CFG_IDX_W = 3;
  localparam int STEP_W    = 5;

  localparam int MUL_STEPS = 8;
  localparam int DIV_STEPS = Q_W;

  localparam logic [GAIN_W-1:0] GAIN_UNITY = GAIN_W'(1 << FRAC_W);
  localparam logic [GAIN_W-1:0] GAIN_MAX   = {GAIN_W{1'b1}};
  localparam logic [PIX_W-1:0]  PIX_MAX    = {PIX_W{1'b1}};
  localparam logic [CNT_W-1:0]  CNT_MAX    = {CNT_W{1'b1}};

  localparam logic KIND_STAT  = 1'b0;
  localparam logic KIND_APPLY = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AUTO   = 3'd0,
    CFG_GAIN_R = 3'd1,
    CFG_GAIN_G = 3'd2,
    CFG_GAIN_B = 3'd3,
    CFG_LOW    = 3'd4,
    CFG_HIGH   = 3'd5
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ACC,
    ST_DECIDE,
    ST_MUL,
    ST_DIV_LOAD,
    ST_DIV_STEP,
    ST_DIV_DONE,
    ST_REPORT,
    ST_PMUL,
    ST_PIX,
    ST_SEND
  } state_e;

  typedef struct packed {
    logic       load_in;
    logic       accumulate;
    logic       clear_stats;
    logic       set_unity;
    logic       mul_en;
    logic [2:0] mul_idx;
    logic       div_load;
    logic       div_step;
    logic       div_done;
    logic       div_sel;
    logic       pix_mul;
    logic       load_pix;
    logic       load_report;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic auto_en;
    logic count_zero;
  } sts_t;

endpackage

// File: src/awb_in_if.sv
interface awb_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [15:0] pixel;
  logic        row_odd;
  logic        col_odd;
  logic        last;

  modport source (output valid, kind, pixel, row_odd, col_odd, last, input ready);
  modport sink   (input valid, kind, pixel, row_odd, col_odd, last, output ready);
endinterface

// File: src/awb_out_if.sv
interface awb_out_if;
  logic        valid;
  logic        ready;
  logic        report_kind;
  logic [15:0] pixel_out;
  logic [17:0] gain_r_out;
  logic [17:0] gain_g_out;
  logic [17:0] gain_b_out;
  logic        fallback;
  logic        end_of_pass;

  modport source (output valid, report_kind, pixel_out, gain_r_out, gain_g_out, gain_b_out,
                  fallback, end_of_pass, input ready);
  modport sink   (input valid, report_kind, pixel_out, gain_r_out, gain_g_out, gain_b_out,
                  fallback, end_of_pass, output ready);
endinterface

// File: src/awb_ctrl.sv
module awb_ctrl import awb_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_kind_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e             state_q, state_d;
  logic [STEP_W-1:0]  cnt_q, cnt_d;
  logic               sel_q, sel_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      sel_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      sel_q   <= sel_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    sel_d   = sel_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (in_kind_i == KIND_APPLY) ? ST_PMUL : ST_ACC;
        end
      end
      ST_ACC: begin
        state_d = sts_i.last ? ST_DECIDE : ST_IDLE;
      end
      ST_DECIDE: begin
        if (!sts_i.auto_en || sts_i.count_zero) begin
          state_d = ST_REPORT;
        end else begin
          state_d = ST_MUL;
          cnt_d   = '0;
        end
      end
      ST_MUL: begin
        if (cnt_q == STEP_W'(MUL_STEPS - 1)) begin
          state_d = ST_DIV_LOAD;
          sel_d   = 1'b0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_DIV_LOAD: begin
        state_d = ST_DIV_STEP;
        cnt_d   = '0;
      end
      ST_DIV_STEP: begin
        if (cnt_q == STEP_W'(DIV_STEPS - 1)) begin
          state_d = ST_DIV_DONE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_DIV_DONE: begin
        if (sel_q) begin
          state_d = ST_REPORT;
        end else begin
          sel_d   = 1'b1;
          state_d = ST_DIV_LOAD;
        end
      end
      ST_REPORT: state_d = ST_SEND;
      ST_PMUL:   state_d = ST_PIX;
      ST_PIX:    state_d = ST_SEND;
      ST_SEND: begin
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load_in = in_valid_i;
      end
      ST_ACC:    cmd_o.accumulate = 1'b1;
      ST_DECIDE: cmd_o.set_unity  = sts_i.auto_en & sts_i.count_zero;
      ST_MUL: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_idx = cnt_q[2:0];
      end
      ST_DIV_LOAD: begin
        cmd_o.div_load = 1'b1;
        cmd_o.div_sel  = sel_q;
      end
      ST_DIV_STEP: cmd_o.div_step = 1'b1;
      ST_DIV_DONE: begin
        cmd_o.div_done = 1'b1;
        cmd_o.div_sel  = sel_q;
      end
      ST_REPORT: begin
        cmd_o.load_report = 1'b1;
        cmd_o.clear_stats = 1'b1;
      end
      ST_PMUL: cmd_o.pix_mul  = 1'b1;
      ST_PIX:  cmd_o.load_pix = 1'b1;
      ST_SEND: out_valid_o    = 1'b1;
      default: cmd_o          = '0;
    endcase
  end

endmodule

// File: src/awb_dp.sv
module awb_dp import awb_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic [PIX_W-1:0]     in_pixel_i,
  input  logic                 in_row_odd_i,
  input  logic                 in_col_odd_i,
  input  logic                 in_last_i,
  input  cmd_t                 cmd_i,
  output sts_t                 sts_o,
  output logic                 report_kind_o,
  output logic [PIX_W-1:0]     pixel_out_o,
  output logic [GAIN_W-1:0]    gain_r_out_o,
  output logic [GAIN_W-1:0]    gain_g_out_o,
  output logic [GAIN_W-1:0]    gain_b_out_o,
  output logic                 fallback_o,
  output logic                 end_of_pass_o
);

  localparam logic [1:0] PROD_GR = 2'd0;  // sum green * count red
  localparam logic [1:0] PROD_RG = 2'd1;  // sum red * count green
  localparam logic [1:0] PROD_GB = 2'd2;  // sum green * count blue
  localparam logic [1:0] PROD_BG = 2'd3;  // sum blue * count green

  localparam int PP_W  = HALF_W + CNT_W;
  localparam int PIXP_W = PIX_W + GAIN_W;
  localparam logic [PIXP_W:0] PIX_ROUND = (PIXP_W + 1)'(1 << (FRAC_W - 1));

  // configuration
  logic              auto_q;
  logic [GAIN_W-1:0] man_r_q, man_g_q, man_b_q;
  logic [PIX_W-1:0]  low_q, high_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      auto_q  <= 1'b1;
      man_r_q <= GAIN_UNITY;
      man_g_q <= GAIN_UNITY;
      man_b_q <= GAIN_UNITY;
      low_q   <= PIX_W'(100);
      high_q  <= PIX_W'(60000);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_AUTO:   auto_q  <= cfg_data_i[0];
        CFG_GAIN_R: man_r_q <= cfg_data_i[GAIN_W-1:0];
        CFG_GAIN_G: man_g_q <= cfg_data_i[GAIN_W-1:0];
        CFG_GAIN_B: man_b_q <= cfg_data_i[GAIN_W-1:0];
        CFG_LOW:    low_q   <= cfg_data_i[PIX_W-1:0];
        CFG_HIGH:   high_q  <= cfg_data_i[PIX_W-1:0];
        default:    ;
      endcase
    end
  end

  // latched input transaction
  logic             rodd_q, codd_q, last_q;
  logic [PIX_W-1:0] pix_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      pix_q  <= in_pixel_i;
      rodd_q <= in_row_odd_i;
      codd_q <= in_col_odd_i;
      last_q <= in_last_i;
    end
  end

  logic is_red, is_blue;
  assign is_red  = !rodd_q && !codd_q;
  assign is_blue = rodd_q && codd_q;

  // gains in use
  logic [GAIN_W-1:0] agr_q, agb_q;
  logic              fb_q;
  logic [GAIN_W-1:0] use_r, use_g, use_b;
  logic              use_fb;

  assign use_r  = auto_q ? agr_q : man_r_q;
  assign use_g  = auto_q ? GAIN_UNITY : man_g_q;
  assign use_b  = auto_q ? agb_q : man_b_q;
  assign use_fb = auto_q & fb_q;

  // statistics
  logic [SUM_W-1:0] sum_r_q, sum_g_q, sum_b_q;
  logic [CNT_W-1:0] cnt_r_q, cnt_g_q, cnt_b_q;
  logic [CNT_W-1:0] cnt_sel;
  logic             in_win, acc_ok;

  assign cnt_sel = is_red ? cnt_r_q : (is_blue ? cnt_b_q : cnt_g_q);
  assign in_win  = (pix_q >= low_q) && (pix_q <= high_q);
  assign acc_ok  = cmd_i.accumulate && auto_q && in_win && (cnt_sel != CNT_MAX);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_r_q <= '0;
      sum_g_q <= '0;
      sum_b_q <= '0;
      cnt_r_q <= '0;
      cnt_g_q <= '0;
      cnt_b_q <= '0;
    end else if (cmd_i.clear_stats) begin
      sum_r_q <= '0;
      sum_g_q <= '0;
      sum_b_q <= '0;
      cnt_r_q <= '0;
      cnt_g_q <= '0;
      cnt_b_q <= '0;
    end else if (acc_ok) begin
      if (is_red) begin
        sum_r_q <= sum_r_q + SUM_W'(pix_q);
        cnt_r_q <= cnt_r_q + 1'b1;
      end else if (is_blue) begin
        sum_b_q <= sum_b_q + SUM_W'(pix_q);
        cnt_b_q <= cnt_b_q + 1'b1;
      end else begin
        sum_g_q <= sum_g_q + SUM_W'(pix_q);
        cnt_g_q <= cnt_g_q + 1'b1;
      end
    end
  end

  assign sts_o.last       = last_q;
  assign sts_o.auto_en    = auto_q;
  assign sts_o.count_zero = (cnt_r_q == '0) || (cnt_g_q == '0) || (cnt_b_q == '0);

  // cross products, one half of a sum per cycle
  logic [PROD_W-1:0] p_gr_q, p_rg_q, p_gb_q, p_bg_q;
  logic [1:0]        mk;
  logic              mh;
  logic [SUM_W-1:0]  ma;
  logic [CNT_W-1:0]  mb;
  logic [HALF_W-1:0] ma_half;
  logic [PP_W-1:0]   pp;
  logic [PROD_W-1:0] p_old, p_new;

  assign mk = cmd_i.mul_idx[2:1];
  assign mh = cmd_i.mul_idx[0];

  always_comb begin
    unique case (mk)
      PROD_GR: begin ma = sum_g_q; mb = cnt_r_q; p_old = p_gr_q; end
      PROD_RG: begin ma = sum_r_q; mb = cnt_g_q; p_old = p_rg_q; end
      PROD_GB: begin ma = sum_g_q; mb = cnt_b_q; p_old = p_gb_q; end
      PROD_BG: begin ma = sum_b_q; mb = cnt_g_q; p_old = p_bg_q; end
      default: begin ma = '0;      mb = '0;      p_old = '0;     end
    endcase
  end

  assign ma_half = mh ? ma[SUM_W-1:HALF_W] : ma[HALF_W-1:0];
  assign pp      = PP_W'(ma_half * mb);
  assign p_new   = mh ? (p_old + PROD_W'({pp, {HALF_W{1'b0}}})) : PROD_W'(pp);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      unique case (mk)
        PROD_GR: p_gr_q <= p_new;
        PROD_RG: p_rg_q <= p_new;
        PROD_GB: p_gb_q <= p_new;
        PROD_BG: p_bg_q <= p_new;
        default: ;
      endcase
    end
  end

  // restoring divider, one quotient bit per cycle; top bit set means saturated
  logic [NUM_W-1:0]  rem_q;
  logic [DEN_W-1:0]  dsh_q;
  logic [Q_W-1:0]    quo_q;
  logic [DEN_W-1:0]  rem_ext;
  logic              div_ge;
  logic [Q_W-1:0]    quo_rnd;
  logic [GAIN_W-1:0] gain_res;

  assign rem_ext = DEN_W'(rem_q);
  assign div_ge  = rem_ext >= dsh_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load) begin
      rem_q <= {(cmd_i.div_sel ? p_gb_q : p_gr_q), {(FRAC_W + 1){1'b0}}};
      dsh_q <= {(cmd_i.div_sel ? p_bg_q : p_rg_q), {(Q_W - 1){1'b0}}};
      quo_q <= '0;
    end else if (cmd_i.div_step) begin
      if (div_ge) begin
        rem_q <= NUM_W'(rem_ext - dsh_q);
      end
      quo_q <= {quo_q[Q_W-2:0], div_ge};
      dsh_q <= dsh_q >> 1;
    end
  end

  assign quo_rnd = (Q_W'({1'b0, quo_q[Q_W-2:0]}) + 1'b1) >> 1;

  always_comb begin
    if (quo_q[Q_W-1] || (quo_rnd > Q_W'(GAIN_MAX))) begin
      gain_res = GAIN_MAX;
    end else begin
      gain_res = quo_rnd[GAIN_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      agr_q <= GAIN_UNITY;
      agb_q <= GAIN_UNITY;
      fb_q  <= 1'b0;
    end else if (cmd_i.set_unity) begin
      agr_q <= GAIN_UNITY;
      agb_q <= GAIN_UNITY;
      fb_q  <= 1'b1;
    end else if (cmd_i.div_done) begin
      if (cmd_i.div_sel) begin
        agb_q <= gain_res;
        fb_q  <= 1'b0;
      end else begin
        agr_q <= gain_res;
      end
    end
  end

  // pixel correction
  logic [GAIN_W-1:0] pix_gain;
  logic [PIXP_W-1:0] pprod_q;
  logic [PIXP_W:0]   pix_rnd;
  logic [PIX_W-1:0]  pix_sat;

  assign pix_gain = is_red ? use_r : (is_blue ? use_b : use_g);

  always_ff @(posedge clk_i) begin
    if (cmd_i.pix_mul) begin
      pprod_q <= PIXP_W'(pix_q * pix_gain);
    end
  end

  assign pix_rnd = ((PIXP_W + 1)'(pprod_q) + PIX_ROUND) >> FRAC_W;
  assign pix_sat = (pix_rnd > (PIXP_W + 1)'(PIX_MAX)) ? PIX_MAX : pix_rnd[PIX_W-1:0];

  // output register
  logic              o_kind_q, o_fb_q, o_eop_q;
  logic [PIX_W-1:0]  o_pix_q;
  logic [GAIN_W-1:0] o_gr_q, o_gg_q, o_gb_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_report || cmd_i.load_pix) begin
      o_gr_q <= use_r;
      o_gg_q <= use_g;
      o_gb_q <= use_b;
      o_fb_q <= use_fb;
      if (cmd_i.load_report) begin
        o_kind_q <= KIND_STAT;
        o_pix_q  <= '0;
        o_eop_q  <= 1'b1;
      end else begin
        o_kind_q <= KIND_APPLY;
        o_pix_q  <= pix_sat;
        o_eop_q  <= last_q;
      end
    end
  end

  assign report_kind_o = o_kind_q;
  assign pixel_out_o   = o_pix_q;
  assign gain_r_out_o  = o_gr_q;
  assign gain_g_out_o  = o_gg_q;
  assign gain_b_out_o  = o_gb_q;
  assign fallback_o    = o_fb_q;
  assign end_of_pass_o = o_eop_q;

endmodule

// File: src/bayer_gray_world_awb_top.sv
// Gray-world white balance for a 16-bit RGGB Bayer stream, sent twice per frame.
// One transaction is in flight at a time. A statistics pixel passes IDLE and ACC; an
// apply pixel passes PMUL, PIX and SEND, waiting there until its result is taken. The
// last statistics pixel goes from DECIDE to REPORT in manual mode or if a colour had
// no pixels in the window; in auto mode it forms the four sum-by-count cross products
// on one 20x24 multiplier, then runs two 20-step restoring divisions (red gain, then
// blue gain). The user must write configuration via cfg_we_i/cfg_idx_i/cfg_data_i
// only while no transaction is in flight; the block does not enforce it.
module bayer_gray_world_awb_top import awb_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  awb_in_if.sink               in_if,
  awb_out_if.source            out_if,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  cmd_t cmd;
  sts_t sts;

  awb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_kind_i   (in_if.kind),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  awb_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_pixel_i    (in_if.pixel),
    .in_row_odd_i  (in_if.row_odd),
    .in_col_odd_i  (in_if.col_odd),
    .in_last_i     (in_if.last),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .report_kind_o (out_if.report_kind),
    .pixel_out_o   (out_if.pixel_out),
    .gain_r_out_o  (out_if.gain_r_out),
    .gain_g_out_o  (out_if.gain_g_out),
    .gain_b_out_o  (out_if.gain_b_out),
    .fallback_o    (out_if.fallback),
    .end_of_pass_o (out_if.end_of_pass)
  );

endmodule

// File: tb/awb_balance_check.sv
`timescale 1ns / 100ps

module awb_balance_check import awb_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  awb_in_if                    in_mon,
  awb_out_if                   out_mon,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  output int                   fail_count_o,
  output int                   pending_o
);

  typedef enum logic [1:0] {
    CLR_RED,
    CLR_GREEN,
    CLR_BLUE
  } bayer_colour_e;

  typedef struct packed {
    logic              report_kind;
    logic [PIX_W-1:0]  pixel;
    logic [GAIN_W-1:0] gain_r;
    logic [GAIN_W-1:0] gain_g;
    logic [GAIN_W-1:0] gain_b;
    logic              fallback;
    logic              end_of_pass;
  } awb_result_t;

  awb_result_t results_due[$];
  int          mismatches;

  // register copies
  logic              auto_en;
  logic [GAIN_W-1:0] man_gain_r, man_gain_g, man_gain_b;
  logic [PIX_W-1:0]  win_low, win_high;

  // statistics and gains carried between passes
  logic [SUM_W-1:0]  colour_sum [3];
  logic [CNT_W-1:0]  colour_cnt [3];
  logic [GAIN_W-1:0] auto_gain_red, auto_gain_blue;
  logic              prev_fallback;

  function automatic bayer_colour_e colour_of(logic ro, logic co);
    if (!ro && !co) return CLR_RED;
    if (ro && co) return CLR_BLUE;
    return CLR_GREEN;
  endfunction

  // round(num_sum * num_cnt * 2^FRAC_W / (den_sum * den_cnt)), saturated
  function automatic logic [GAIN_W-1:0] mean_ratio_gain(logic [SUM_W-1:0] num_sum,
                                                        logic [CNT_W-1:0] num_cnt,
                                                        logic [SUM_W-1:0] den_sum,
                                                        logic [CNT_W-1:0] den_cnt);
    logic [127:0] num, den, q;
    num = (128'(num_sum) * 128'(num_cnt)) << (FRAC_W + 1);
    den = 128'(den_sum) * 128'(den_cnt);
    // also covers a zero denominator
    if (num >= (den << (Q_W - 1))) return GAIN_MAX;
    q = num / den;
    q = (q + 1) >> 1;
    return (q > 128'(GAIN_MAX)) ? GAIN_MAX : q[GAIN_W-1:0];
  endfunction

  function automatic logic [PIX_W-1:0] scale_pixel(logic [PIX_W-1:0] pix,
                                                   logic [GAIN_W-1:0] gain);
    logic [PIX_W+GAIN_W+1:0] scaled;
    scaled = (36'(pix) * 36'(gain) + 36'(1 << (FRAC_W - 1))) >> FRAC_W;
    return (scaled > 36'(PIX_MAX)) ? PIX_MAX : scaled[PIX_W-1:0];
  endfunction

  task automatic check_field(input string field, input logic [GAIN_W-1:0] want,
                             input logic [GAIN_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      mismatches++;
    end
  endtask

  task automatic predict_transaction();
    bayer_colour_e     colour;
    logic [GAIN_W-1:0] gr, gg, gb;
    logic              fb;
    awb_result_t       res;
    colour = colour_of(in_mon.row_odd, in_mon.col_odd);
    if (auto_en) begin
      gr = auto_gain_red;
      gg = GAIN_UNITY;
      gb = auto_gain_blue;
      fb = prev_fallback;
    end else begin
      gr = man_gain_r;
      gg = man_gain_g;
      gb = man_gain_b;
      fb = 1'b0;
    end

    if (in_mon.kind == KIND_STAT) begin
      if (auto_en && in_mon.pixel >= win_low && in_mon.pixel <= win_high &&
          colour_cnt[colour] != CNT_MAX) begin
        colour_sum[colour] += SUM_W'(in_mon.pixel);
        colour_cnt[colour] += 1'b1;
      end
      if (!in_mon.last) return;
      if (auto_en) begin
        if (colour_cnt[CLR_RED] == '0 || colour_cnt[CLR_GREEN] == '0 ||
            colour_cnt[CLR_BLUE] == '0) begin
          auto_gain_red  = GAIN_UNITY;
          auto_gain_blue = GAIN_UNITY;
          prev_fallback  = 1'b1;
        end else begin
          auto_gain_red  = mean_ratio_gain(colour_sum[CLR_GREEN], colour_cnt[CLR_RED],
                                           colour_sum[CLR_RED], colour_cnt[CLR_GREEN]);
          auto_gain_blue = mean_ratio_gain(colour_sum[CLR_GREEN], colour_cnt[CLR_BLUE],
                                           colour_sum[CLR_BLUE], colour_cnt[CLR_GREEN]);
          prev_fallback  = 1'b0;
        end
        gr = auto_gain_red;
        gb = auto_gain_blue;
        fb = prev_fallback;
      end
      foreach (colour_sum[i]) begin
        colour_sum[i] = '0;
        colour_cnt[i] = '0;
      end
      res = '{report_kind: KIND_STAT, pixel: '0, gain_r: gr, gain_g: gg, gain_b: gb,
              fallback: fb, end_of_pass: 1'b1};
    end else begin
      res = '{report_kind: KIND_APPLY,
              pixel: scale_pixel(in_mon.pixel,
                                 colour == CLR_RED ? gr : (colour == CLR_BLUE ? gb : gg)),
              gain_r: gr, gain_g: gg, gain_b: gb, fallback: fb,
              end_of_pass: in_mon.last};
    end
    results_due.push_back(res);
  endtask

  task automatic compare_transaction();
    awb_result_t want;
    if (results_due.size() == 0) begin
      $display("%0t: unexpected result transaction, kind %0d pixel %0d", $time,
               out_mon.report_kind, out_mon.pixel_out);
      mismatches++;
      return;
    end
    want = results_due.pop_front();
    check_field("report_kind", want.report_kind, out_mon.report_kind);
    check_field("pixel_out", want.pixel, out_mon.pixel_out);
    check_field("gain_r_out", want.gain_r, out_mon.gain_r_out);
    check_field("gain_g_out", want.gain_g, out_mon.gain_g_out);
    check_field("gain_b_out", want.gain_b, out_mon.gain_b_out);
    check_field("fallback", want.fallback, out_mon.fallback);
    check_field("end_of_pass", want.end_of_pass, out_mon.end_of_pass);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      auto_en        = 1'b1;
      man_gain_r     = GAIN_UNITY;
      man_gain_g     = GAIN_UNITY;
      man_gain_b     = GAIN_UNITY;
      win_low        = 16'd100;
      win_high       = 16'd60000;
      auto_gain_red  = GAIN_UNITY;
      auto_gain_blue = GAIN_UNITY;
      prev_fallback  = 1'b0;
      foreach (colour_sum[i]) begin
        colour_sum[i] = '0;
        colour_cnt[i] = '0;
      end
      results_due.delete();
      mismatches    = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_AUTO:   auto_en    = cfg_data_i[0];
          CFG_GAIN_R: man_gain_r = cfg_data_i[GAIN_W-1:0];
          CFG_GAIN_G: man_gain_g = cfg_data_i[GAIN_W-1:0];
          CFG_GAIN_B: man_gain_b = cfg_data_i[GAIN_W-1:0];
          CFG_LOW:    win_low    = cfg_data_i[PIX_W-1:0];
          CFG_HIGH:   win_high   = cfg_data_i[PIX_W-1:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) predict_transaction();
      if (out_mon.valid && out_mon.ready) compare_transaction();
      fail_count_o <= mismatches;
      pending_o    <= results_due.size();
    end
  end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import awb_pkg::*;

  localparam int ITEM_TARGET = 1425;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i;
  cfg_idx_e             cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;
  int                   fail_count;
  int                   pending;
  int                   items_sent = 0;
  bit                   quiet = 1'b0;

  awb_in_if  in_if ();
  awb_out_if out_if ();

  bayer_gray_world_awb_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_if      (in_if),
    .out_if     (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  awb_balance_check balance_mon (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (in_if),
    .out_mon      (out_if),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("simulation failed");
    $finish;
  end

  // mostly short gaps, a few long ones, none in quiet stretches
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // result side back-pressure
  initial begin
    int stall;
    out_if.ready <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      stall = idle_len();
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      repeat (quiet ? 20 : $urandom_range(1, 12)) @(posedge clk_i);
    end
  end

  task automatic send_px(input logic kind, input logic [PIX_W-1:0] pix,
                         input logic ro, input logic co, input logic lst);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.kind    <= kind;
    in_if.pixel   <= pix;
    in_if.row_odd <= ro;
    in_if.col_odd <= co;
    in_if.last    <= lst;
    do @(posedge clk_i); while (!in_if.ready);
    items_sent++;
  endtask

  // hold the sender until every result is back and the block has settled
  task automatic drain_results();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic cfg_write(input cfg_idx_e idx, input logic [CFG_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [GAIN_W-1:0] pick_gain();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return GAIN_MAX;
      2:       return GAIN_UNITY;
      5:       return GAIN_W'($urandom_range(0, 262143));
      default: return GAIN_W'($urandom_range(256, 4096));
    endcase
  endfunction

  task automatic random_config();
    drain_results();
    if ($urandom_range(0, 1)) cfg_write(CFG_AUTO, CFG_W'($urandom_range(0, 3) != 0));
    if ($urandom_range(0, 1)) cfg_write(CFG_GAIN_R, pick_gain());
    if ($urandom_range(0, 1)) cfg_write(CFG_GAIN_G, pick_gain());
    if ($urandom_range(0, 1)) cfg_write(CFG_GAIN_B, pick_gain());
    if ($urandom_range(0, 1)) begin
      case ($urandom_range(0, 5))
        0:       cfg_write(CFG_LOW, '0);
        1:       cfg_write(CFG_LOW, CFG_W'($urandom_range(0, 65535)));
        2:       cfg_write(CFG_LOW, CFG_W'(PIX_MAX));
        default: cfg_write(CFG_LOW, CFG_W'($urandom_range(0, 500)));
      endcase
    end
    if ($urandom_range(0, 1)) begin
      case ($urandom_range(0, 5))
        0:       cfg_write(CFG_HIGH, CFG_W'(PIX_MAX));
        1:       cfg_write(CFG_HIGH, CFG_W'($urandom_range(0, 65535)));
        2:       cfg_write(CFG_HIGH, '0);
        default: cfg_write(CFG_HIGH, CFG_W'($urandom_range(50000, 65535)));
      endcase
    end
  endtask

  function automatic logic [PIX_W-1:0] near_level(int level);
    int spread, v;
    spread = level / 8 + 1;
    case ($urandom_range(0, 19))
      0:       return PIX_W'($urandom);
      1:       return $urandom_range(0, 1) ? PIX_MAX : '0;
      default: begin
        v = level + int'($urandom_range(0, 2 * spread)) - spread;
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        return PIX_W'(v);
      end
    endcase
  endfunction

  // statistics pass over an RGGB tile grid, then the apply pass over the same pixels
  task automatic run_frame(input int w, input int h);
    logic [PIX_W-1:0] frame_px[$];
    int               lvl[4];
    int               k;
    foreach (lvl[i]) lvl[i] = $urandom_range(150, 40000);
    for (int r = 0; r < h; r++) begin
      for (int c = 0; c < w; c++) begin
        frame_px.push_back(near_level(lvl[{r[0], c[0]}]));
        send_px(KIND_STAT, frame_px[$], r[0], c[0], r == h - 1 && c == w - 1);
      end
    end
    k = 0;
    for (int r = 0; r < h; r++) begin
      for (int c = 0; c < w; c++) begin
        send_px(KIND_APPLY, frame_px[k], r[0], c[0], r == h - 1 && c == w - 1);
        k++;
      end
    end
  endtask

  // short broken passes or loose noise with random fields
  task automatic send_scrap(input bit stat_only);
    int n;
    n = $urandom_range(1, 8);
    for (int i = 0; i < n; i++) begin
      send_px(stat_only ? KIND_STAT : logic'($urandom_range(0, 1)), PIX_W'($urandom),
              logic'($urandom_range(0, 1)), logic'($urandom_range(0, 1)),
              stat_only ? logic'(i == n - 1) : logic'($urandom_range(0, 7) == 0));
    end
  endtask

  initial begin
    int until_cfg;
    int pick;
    in_if.valid   <= 1'b0;
    in_if.kind    <= KIND_STAT;
    in_if.pixel   <= '0;
    in_if.row_odd <= 1'b0;
    in_if.col_odd <= 1'b0;
    in_if.last    <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= CFG_AUTO;
    cfg_data_i    <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset window: red mean 1000, green 2000, blue 4000
    send_px(KIND_STAT, 16'd1000, 1'b0, 1'b0, 1'b0);
    send_px(KIND_STAT, 16'd2000, 1'b0, 1'b1, 1'b0);
    send_px(KIND_STAT, 16'd2000, 1'b1, 1'b0, 1'b0);
    send_px(KIND_STAT, 16'd4000, 1'b1, 1'b1, 1'b1);
    // pixel saturation and zero
    send_px(KIND_APPLY, PIX_MAX, 1'b0, 1'b0, 1'b0);
    send_px(KIND_APPLY, 16'd0, 1'b0, 1'b1, 1'b0);
    send_px(KIND_APPLY, PIX_MAX, 1'b1, 1'b0, 1'b0);
    send_px(KIND_APPLY, 16'd40000, 1'b1, 1'b1, 1'b1);
    // window edges, red only outside the window so its count stays zero
    send_px(KIND_STAT, 16'd99, 1'b0, 1'b0, 1'b0);
    send_px(KIND_STAT, 16'd60001, 1'b0, 1'b0, 1'b0);
    send_px(KIND_STAT, 16'd100, 1'b0, 1'b1, 1'b0);
    send_px(KIND_STAT, 16'd60000, 1'b1, 1'b1, 1'b1);
    send_px(KIND_APPLY, 16'd12345, 1'b0, 1'b0, 1'b1);
    // one-pixel pass
    send_px(KIND_STAT, 16'd500, 1'b1, 1'b1, 1'b1);

    drain_results();
    cfg_write(CFG_LOW, '0);
    cfg_write(CFG_HIGH, CFG_W'(PIX_MAX));
    // zero red mean and a tiny blue mean, both gains saturate
    send_px(KIND_STAT, 16'd0, 1'b0, 1'b0, 1'b0);
    send_px(KIND_STAT, PIX_MAX, 1'b0, 1'b1, 1'b0);
    send_px(KIND_STAT, PIX_MAX, 1'b1, 1'b0, 1'b0);
    send_px(KIND_STAT, 16'd1, 1'b1, 1'b1, 1'b1);
    send_px(KIND_APPLY, PIX_MAX, 1'b1, 1'b1, 1'b0);
    send_px(KIND_APPLY, 16'd1, 1'b0, 1'b0, 1'b1);

    drain_results();
    cfg_write(CFG_AUTO, '0);
    cfg_write(CFG_GAIN_R, '0);
    cfg_write(CFG_GAIN_G, CFG_W'(GAIN_MAX));
    cfg_write(CFG_GAIN_B, CFG_W'(1536));
    // manual mode: no statistics, report carries the manual gains
    send_px(KIND_STAT, 16'd777, 1'b0, 1'b1, 1'b0);
    send_px(KIND_STAT, 16'd777, 1'b1, 1'b1, 1'b1);
    send_px(KIND_APPLY, PIX_MAX, 1'b0, 1'b0, 1'b0);
    send_px(KIND_APPLY, PIX_MAX, 1'b0, 1'b1, 1'b0);
    send_px(KIND_APPLY, 16'd3, 1'b1, 1'b1, 1'b1);

    drain_results();
    cfg_write(CFG_AUTO, CFG_W'(1));
    cfg_write(CFG_LOW, CFG_W'(100));
    cfg_write(CFG_HIGH, CFG_W'(60000));

    until_cfg = 6;
    while (items_sent < ITEM_TARGET) begin
      if (until_cfg == 0) begin
        random_config();
        until_cfg = $urandom_range(4, 10);
      end
      until_cfg--;
      quiet = ($urandom_range(0, 4) == 0);
      pick  = $urandom_range(0, 19);
      if (pick == 0) run_frame(16, 8);
      else if (pick < 16) run_frame(2 * $urandom_range(1, 4), 2 * $urandom_range(1, 3));
      else if (pick < 18) send_scrap(1'b1);
      else send_scrap(1'b0);
    end
    quiet = 1'b0;

    drain_results();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
